### hdl/ald_pkg.sv
package ald_pkg;

    localparam int ACCEL_BITS = 16;
    localparam int SQ_BITS    = 31;
    localparam int LEVEL_BITS = 32;
    localparam int STAMP_BITS = 32;
    localparam int HOLD_BITS  = 16;

    localparam logic [1:0] ROT_0 = 2'd0;
    localparam logic [1:0] ROT_1 = 2'd1;
    localparam logic [1:0] ROT_2 = 2'd2;
    localparam logic [1:0] ROT_3 = 2'd3;
    localparam logic [2:0] NO_CANDIDATE = 3'd4;

    localparam logic [1:0] REG_ORIENT_HOLD   = 2'd0;
    localparam logic [1:0] REG_LIFT_COOLDOWN = 2'd1;
    localparam logic [1:0] REG_LIFT_LEVEL    = 2'd2;
    localparam logic [1:0] REG_START_ROT     = 2'd3;

    localparam logic [HOLD_BITS-1:0]  HOLD_RESET     = 16'd500;
    localparam logic [HOLD_BITS-1:0]  COOLDOWN_RESET = 16'd1500;
    localparam logic [LEVEL_BITS-1:0] LEVEL_RESET    = 32'd30580900;
    localparam logic [1:0]            START_RESET    = ROT_0;

    typedef struct packed {
        logic [HOLD_BITS-1:0]  orient_hold_ms;
        logic [HOLD_BITS-1:0]  lift_gap_ms;
        logic [LEVEL_BITS-1:0] lift_level_sq;
        logic [1:0]            start_rotation;
        logic                  rot_load;
    } cfg_t;

    typedef struct packed {
        logic [1:0]            rot;
        logic [SQ_BITS-1:0]    sq_x;
        logic [SQ_BITS-1:0]    sq_y;
        logic [SQ_BITS-1:0]    sq_z;
        logic [STAMP_BITS-1:0] time_ms;
    } mid_t;

endpackage

### hdl/ald_sample_if.sv
interface ald_sample_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic        [31:0] time_ms;

    modport source (output valid, accel_x, accel_y, accel_z, time_ms, input ready);
    modport sink (input valid, accel_x, accel_y, accel_z, time_ms, output ready);
endinterface

### hdl/ald_result_if.sv
interface ald_result_if;
    logic       valid;
    logic       ready;
    logic       orient_event;
    logic [1:0] rotation;
    logic       lift_event;

    modport source (output valid, orient_event, rotation, lift_event, input ready);
    modport sink (input valid, orient_event, rotation, lift_event, output ready);
endinterface

### hdl/ald_cfg.sv
module ald_cfg (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [3:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    output ald_pkg::cfg_t cfg
);
    import ald_pkg::*;

    logic [HOLD_BITS-1:0]  hold_reg;
    logic [HOLD_BITS-1:0]  cooldown_reg;
    logic [LEVEL_BITS-1:0] level_reg;
    logic [1:0]            start_reg;
    logic                  load_reg;
    logic                  wr_en;
    logic [1:0]            idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg     <= HOLD_RESET;
            cooldown_reg <= COOLDOWN_RESET;
            level_reg    <= LEVEL_RESET;
            start_reg    <= START_RESET;
            load_reg     <= 1'b0;
        end
        else
        begin
            load_reg <= 1'b0;
            if (wr_en)
            begin
                case (idx)
                    REG_ORIENT_HOLD:   hold_reg     <= pwdata[HOLD_BITS-1:0];
                    REG_LIFT_COOLDOWN: cooldown_reg <= pwdata[HOLD_BITS-1:0];
                    REG_LIFT_LEVEL:    level_reg    <= pwdata[LEVEL_BITS-1:0];
                    REG_START_ROT:
                    begin
                        start_reg <= pwdata[1:0];
                        load_reg  <= 1'b1;
                    end
                    default: ;
                endcase
            end
        end
    end

    always_comb
    begin
        case (idx)
            REG_ORIENT_HOLD:   prdata = 32'(hold_reg);
            REG_LIFT_COOLDOWN: prdata = 32'(cooldown_reg);
            REG_LIFT_LEVEL:    prdata = level_reg;
            REG_START_ROT:     prdata = 32'(start_reg);
            default:           prdata = '0;
        endcase
    end

    assign cfg.orient_hold_ms = hold_reg;
    assign cfg.lift_gap_ms    = cooldown_reg;
    assign cfg.lift_level_sq  = level_reg;
    assign cfg.start_rotation = start_reg;
    assign cfg.rot_load       = load_reg;

endmodule

### hdl/ald_classify.sv
module ald_classify (
    input  logic          clk,
    input  logic          rst_n,
    ald_sample_if.sink    smp,
    input  logic          mid_take,
    output logic          mid_valid,
    output ald_pkg::mid_t mid
);
    import ald_pkg::*;

    logic                         in_valid_reg;
    logic signed [ACCEL_BITS-1:0] x_reg;
    logic signed [ACCEL_BITS-1:0] y_reg;
    logic signed [ACCEL_BITS-1:0] z_reg;
    logic        [STAMP_BITS-1:0] t_reg;
    logic                         mid_valid_reg;
    mid_t                         mid_reg;
    mid_t                         mid_next;
    logic                         mid_free;
    logic                         in_move;
    logic        [ACCEL_BITS:0]   abs_x;
    logic        [ACCEL_BITS:0]   abs_y;
    logic signed [2*ACCEL_BITS-1:0] px;
    logic signed [2*ACCEL_BITS-1:0] py;
    logic signed [2*ACCEL_BITS-1:0] pz;

    assign mid_free  = !mid_valid_reg || mid_take;
    assign in_move   = in_valid_reg && mid_free;
    assign smp.ready = !in_valid_reg || mid_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (smp.ready)
        begin
            in_valid_reg <= smp.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (smp.valid && smp.ready)
        begin
            x_reg <= smp.accel_x;
            y_reg <= smp.accel_y;
            z_reg <= smp.accel_z;
            t_reg <= smp.time_ms;
        end
    end

    always_comb
    begin
        abs_x = x_reg[ACCEL_BITS-1] ? (ACCEL_BITS+1)'(-x_reg) : {1'b0, x_reg};
        abs_y = y_reg[ACCEL_BITS-1] ? (ACCEL_BITS+1)'(-y_reg) : {1'b0, y_reg};
        if (x_reg[ACCEL_BITS-1])
        begin
            abs_x = (ACCEL_BITS+1)'(0) - {x_reg[ACCEL_BITS-1], x_reg};
        end
        if (y_reg[ACCEL_BITS-1])
        begin
            abs_y = (ACCEL_BITS+1)'(0) - {y_reg[ACCEL_BITS-1], y_reg};
        end
        px = x_reg * x_reg;
        py = y_reg * y_reg;
        pz = z_reg * z_reg;
        if (abs_x > abs_y)
        begin
            mid_next.rot = (!x_reg[ACCEL_BITS-1] && x_reg != '0) ? ROT_2 : ROT_0;
        end
        else
        begin
            mid_next.rot = (!y_reg[ACCEL_BITS-1] && y_reg != '0) ? ROT_1 : ROT_3;
        end
        mid_next.sq_x    = px[SQ_BITS-1:0];
        mid_next.sq_y    = py[SQ_BITS-1:0];
        mid_next.sq_z    = pz[SQ_BITS-1:0];
        mid_next.time_ms = t_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_valid_reg <= 1'b0;
        end
        else if (mid_free)
        begin
            mid_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_move)
        begin
            mid_reg <= mid_next;
        end
    end

    assign mid_valid = mid_valid_reg;
    assign mid       = mid_reg;

endmodule

### hdl/ald_track.sv
module ald_track #(
    parameter int TIME_BITS = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  ald_pkg::cfg_t cfg,
    input  logic          mid_valid,
    input  ald_pkg::mid_t mid,
    output logic          mid_take,
    ald_result_if.source  res
);
    import ald_pkg::*;

    localparam int EXT_BITS = (TIME_BITS > STAMP_BITS) ? TIME_BITS : STAMP_BITS;

    logic [1:0]            committed_reg;
    logic [1:0]            committed_next;
    logic [2:0]            cand_reg;
    logic [2:0]            cand_next;
    logic [TIME_BITS-1:0]  since_reg;
    logic [TIME_BITS-1:0]  since_next;
    logic [TIME_BITS-1:0]  last_lift_reg;
    logic [TIME_BITS-1:0]  last_lift_next;
    logic                  out_valid_reg;
    logic                  orient_reg;
    logic                  orient_next;
    logic [1:0]            rot_out_reg;
    logic                  lift_reg;
    logic                  lift_next;
    logic                  advance;
    logic [EXT_BITS-1:0]   time_ext;
    logic [TIME_BITS-1:0]  now;
    logic [TIME_BITS-1:0]  held;
    logic [TIME_BITS-1:0]  since_lift;
    logic [LEVEL_BITS-1:0] mag_sq;
    logic                  over_level;

    assign advance  = mid_valid && (!out_valid_reg || res.ready);
    assign mid_take = advance;

    assign time_ext   = EXT_BITS'(mid.time_ms);
    assign now        = time_ext[TIME_BITS-1:0];
    assign held       = now - since_reg;
    assign since_lift = now - last_lift_reg;
    assign mag_sq     = LEVEL_BITS'(mid.sq_x) + LEVEL_BITS'(mid.sq_y)
                      + LEVEL_BITS'(mid.sq_z);
    assign over_level = mag_sq > cfg.lift_level_sq;

    always_comb
    begin
        committed_next = committed_reg;
        cand_next      = cand_reg;
        since_next     = since_reg;
        orient_next    = 1'b0;
        last_lift_next = last_lift_reg;
        lift_next      = 1'b0;
        if (mid.rot == committed_reg)
        begin
            cand_next = {1'b0, mid.rot};
        end
        else if ({1'b0, mid.rot} != cand_reg)
        begin
            cand_next  = {1'b0, mid.rot};
            since_next = now;
        end
        else if (held >= TIME_BITS'(cfg.orient_hold_ms))
        begin
            committed_next = mid.rot;
            orient_next    = 1'b1;
        end
        if (over_level && since_lift > TIME_BITS'(cfg.lift_gap_ms))
        begin
            last_lift_next = now;
            lift_next      = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            committed_reg <= START_RESET;
            cand_reg      <= NO_CANDIDATE;
            since_reg     <= '0;
            last_lift_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                committed_reg <= committed_next;
                cand_reg      <= cand_next;
                since_reg     <= since_next;
                last_lift_reg <= last_lift_next;
                out_valid_reg <= 1'b1;
            end
            else
            begin
                if (cfg.rot_load)
                begin
                    committed_reg <= cfg.start_rotation;
                end
                if (res.ready)
                begin
                    out_valid_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            orient_reg  <= orient_next;
            rot_out_reg <= committed_next;
            lift_reg    <= lift_next;
        end
    end

    assign res.valid        = out_valid_reg;
    assign res.orient_event = orient_reg;
    assign res.rotation     = rot_out_reg;
    assign res.lift_event   = lift_reg;

    a_commit_needs_candidate: assert property (@(posedge clk) disable iff (!rst_n)
        advance && orient_next |-> cand_reg == {1'b0, mid.rot})
        else $error("rotation committed without a held candidate");

    a_lift_records_time: assert property (@(posedge clk) disable iff (!rst_n)
        advance && lift_next |=> last_lift_reg == $past(now))
        else $error("lift time not recorded");

    a_candidate_code: assert property (@(posedge clk) disable iff (!rst_n)
        cand_reg <= NO_CANDIDATE)
        else $error("candidate code out of range");

    a_orient_changes_rotation: assert property (@(posedge clk) disable iff (!rst_n)
        advance && orient_next |-> committed_next != committed_reg)
        else $error("orientation beat without a rotation change");

endmodule

### hdl/accel_orientation_lift_detector.sv
// Accelerometer orientation and lift detector.
// Sample channel (smp): one beat carries accel_x/y/z (signed, 1/4096 g) and
// a millisecond timestamp time_ms. Result channel (res): one beat per sample
// with orient_event, the committed rotation and lift_event.
// Configuration: APB writes to orient_hold_ms (0x0), lift cooldown (0x4),
// lift_level_sq (0x8) and start_rotation (0xC); write only while idle.
// Writing start_rotation loads the committed rotation if no beat advances.
// Each sample passes through the input register, the square and classify stage
// and the tracking stage to the output register. Throughput: one sample per
// cycle while res.ready is high; the tracking stage updates the orientation
// and lift state once per beat.
// Reset: restores register defaults, committed rotation 0, no candidate,
// timestamps zero, and empties the pipe.
// Stall: when res.ready is low the result holds; stages behind it keep filling
// until the input register is occupied, then smp.ready drops.
module accel_orientation_lift_detector #(
    parameter int TIME_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    ald_sample_if.sink  smp,
    ald_result_if.source res
);
    import ald_pkg::*;

    cfg_t cfg;
    mid_t mid;
    logic mid_valid;
    logic mid_take;

    ald_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ald_classify u_classify (
        .clk       (clk),
        .rst_n     (rst_n),
        .smp       (smp),
        .mid_take  (mid_take),
        .mid_valid (mid_valid),
        .mid       (mid)
    );

    ald_track #(
        .TIME_BITS (TIME_BITS)
    ) u_track (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .mid_valid (mid_valid),
        .mid       (mid),
        .mid_take  (mid_take),
        .res       (res)
    );

endmodule
